>>> rtl/core/efssc_pkg.sv
// ----------------------------------------------------------------------------
// efssc_pkg
// Shared widths, fixed-point constants and control types for the eased
// fade / scale / slide curve pipeline.
// ----------------------------------------------------------------------------
package efssc_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int TIME_BITS    = 32;
    localparam int Q_W          = FRAC_BITS + 1;
    localparam int PROD_W       = 2 * Q_W;
    localparam int DIV_STEPS    = FRAC_BITS;
    // input stage + one stage per quotient bit + square, cube, curve, output
    localparam int PIPE_LATENCY = DIV_STEPS + 5;

    localparam logic [Q_W-1:0]    ONE_Q  = Q_W'(1) << FRAC_BITS;
    localparam logic [PROD_W-1:0] HALF_P = PROD_W'(1) << (FRAC_BITS - 1);

    // curve constants, round(c * ONE)
    localparam logic [Q_W-1:0] KQ_96 = Q_W'(((64'd96 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [Q_W-1:0] KQ_4  = Q_W'(((64'd4  << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [Q_W-1:0] KQ_75 = Q_W'(((64'd75 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [Q_W-1:0] KQ_90 = Q_W'(((64'd90 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [Q_W-1:0] KQ_10 = Q_W'(((64'd10 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [Q_W-1:0] KQ_50 = Q_W'(((64'd50 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [Q_W-1:0] KQ_8  = Q_W'(((64'd8  << FRAC_BITS) + 64'd50) / 64'd100);

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_FADE  = 2'd1;
    localparam logic [1:0] KIND_SLIDE = 2'd2;
    localparam logic [1:0] KIND_SCALE = 2'd3;

    typedef struct packed {
        logic       valid;
        logic       is_exit;
        logic [1:0] kind;
        logic       reduced;
        logic       at_end;
    } ctl_t;

    // rounded Q1.FRAC_BITS product
    function automatic logic [Q_W-1:0] qround(input logic [PROD_W-1:0] prod);
        logic [PROD_W-1:0] sum;
        sum    = prod + HALF_P;
        qround = Q_W'(sum >> FRAC_BITS);
    endfunction

endpackage

>>> rtl/core/eased_fade_scale_slide_curve_top.sv
// ----------------------------------------------------------------------------
// eased_fade_scale_slide_curve_top
// Cubic eased opacity / scale / slide curve for enter and exit animations.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken on any clock edge where start is high and busy is low.
//   busy never rises, so one item may be issued every cycle.
//   Each result is on the result ports with done high for one cycle, in issue
//   order. Throughput is one item per cycle.
//   The pipeline is the progress divider: one restoring step per quotient
//   bit, one pipeline stage each (16 stages), plus input, square, cube,
//   curve and output stages.
//   The receiver cannot stall; results are not held.
//   reduced_motion_ticks is written over the cfg channel (cfg_ready is
//   always high) and should only be changed while no items are in flight.
//   Reset clears the pipeline valid bits, done and the register (to 0).
// ----------------------------------------------------------------------------
module eased_fade_scale_slide_curve_top
    import efssc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic [31:0] elapsed_ticks,
    input  logic [31:0] duration_ticks,
    input  logic [1:0]  animation_kind,
    input  logic        reduced_motion,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    output logic        done,
    output logic [16:0] opacity_q16,
    output logic [16:0] scale_q16,
    output logic [15:0] slide_offset_q16,
    output logic        finished
);

    logic [TIME_BITS-1:0] reduced_motion_ticks_reg;

    // divider pipeline
    ctl_t                 ctl_reg [0:DIV_STEPS];
    logic [TIME_BITS-1:0] rem_reg [0:DIV_STEPS-1];
    logic [TIME_BITS-1:0] den_reg [0:DIV_STEPS-1];
    logic [FRAC_BITS-1:0] quo_reg [0:DIV_STEPS];

    // easing pipeline
    ctl_t                 ctl_m1_reg, ctl_m2_reg, ctl_m3_reg;
    logic [FRAC_BITS-1:0] t1_reg, t2_reg, t3_reg;
    logic [Q_W-1:0]       u_reg, sq_reg, cube_reg;
    logic [Q_W-1:0]       p_reg, scale_mul_reg, slide_mul_reg;

    logic [TIME_BITS-1:0] dur_sel;
    logic                 at_end_in;
    ctl_t                 ctl_in;

    logic [Q_W-1:0]       u_next, p_next, scale_k, slide_k, slide_base;
    logic [PROD_W-1:0]    sq_prod, cube_prod, scale_prod, slide_prod;

    logic [Q_W-1:0]       opacity_next, slide_next;
    logic [Q_W:0]         scale_next;
    logic                 finished_next;

    logic                 done_reg;
    logic [16:0]          opacity_reg, scale_reg;
    logic [15:0]          slide_reg;
    logic                 finished_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reduced_motion_ticks_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            reduced_motion_ticks_reg <= TIME_BITS'(cfg_data);
        end
    end

    // ---------------- input stage ----------------
    always_comb
    begin
        dur_sel   = reduced_motion ? reduced_motion_ticks_reg : TIME_BITS'(duration_ticks);
        at_end_in = (animation_kind == KIND_NONE) || (dur_sel == '0) ||
                    (TIME_BITS'(elapsed_ticks) >= dur_sel);
        ctl_in.valid   = start && !busy;
        ctl_in.is_exit = req_type;
        ctl_in.kind    = animation_kind;
        ctl_in.reduced = reduced_motion;
        ctl_in.at_end  = at_end_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg[0] <= '0;
        end
        else
        begin
            ctl_reg[0] <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= TIME_BITS'(elapsed_ticks);
        den_reg[0] <= dur_sel;
        quo_reg[0] <= '0;
    end

    // ---------------- restoring divider, one quotient bit per stage ----------------
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        logic [TIME_BITS:0] shifted;
        logic [TIME_BITS:0] diff;
        logic               ge;

        assign shifted = {rem_reg[k], 1'b0};
        assign diff    = shifted - {1'b0, den_reg[k]};
        assign ge      = (shifted >= {1'b0, den_reg[k]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[k+1] <= '0;
            end
            else
            begin
                ctl_reg[k+1] <= ctl_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            quo_reg[k+1] <= {quo_reg[k][FRAC_BITS-2:0], ge};
        end

        if (k + 1 < DIV_STEPS)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[k+1] <= ge ? diff[TIME_BITS-1:0] : shifted[TIME_BITS-1:0];
                den_reg[k+1] <= den_reg[k];
            end
        end
    end

    // ---------------- square ----------------
    always_comb
    begin
        u_next  = ctl_reg[DIV_STEPS].is_exit ? {1'b0, quo_reg[DIV_STEPS]}
                                             : ONE_Q - {1'b0, quo_reg[DIV_STEPS]};
        sq_prod = PROD_W'(u_next) * PROD_W'(u_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_m1_reg <= '0;
        end
        else
        begin
            ctl_m1_reg <= ctl_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        t1_reg <= quo_reg[DIV_STEPS];
        u_reg  <= u_next;
        sq_reg <= qround(sq_prod);
    end

    // ---------------- cube ----------------
    assign cube_prod = PROD_W'(sq_reg) * PROD_W'(u_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_m2_reg <= '0;
        end
        else
        begin
            ctl_m2_reg <= ctl_m1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t2_reg   <= t1_reg;
        cube_reg <= qround(cube_prod);
    end

    // ---------------- eased progress and curve products ----------------
    always_comb
    begin
        if (ctl_m2_reg.is_exit)
        begin
            p_next     = cube_reg;
            scale_k    = KQ_8;
            slide_k    = KQ_50;
            slide_base = cube_reg;
        end
        else
        begin
            p_next     = ONE_Q - cube_reg;
            scale_k    = (ctl_m2_reg.kind == KIND_SLIDE) ? KQ_4 : KQ_10;
            slide_k    = KQ_75;
            slide_base = cube_reg;    // 1 - p on ease-out
        end
        scale_prod = PROD_W'(scale_k) * PROD_W'(p_next);
        slide_prod = PROD_W'(slide_k) * PROD_W'(slide_base);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_m3_reg <= '0;
        end
        else
        begin
            ctl_m3_reg <= ctl_m2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t3_reg        <= t2_reg;
        p_reg         <= p_next;
        scale_mul_reg <= qround(scale_prod);
        slide_mul_reg <= qround(slide_prod);
    end

    // ---------------- output selection ----------------
    always_comb
    begin
        opacity_next  = ctl_m3_reg.is_exit ? ONE_Q - p_reg : p_reg;
        scale_next    = {1'b0, ONE_Q};
        slide_next    = '0;
        finished_next = 1'b0;

        if (ctl_m3_reg.at_end)
        begin
            opacity_next  = ctl_m3_reg.is_exit ? '0 : ONE_Q;
            finished_next = 1'b1;
        end
        else if (ctl_m3_reg.reduced)
        begin
            opacity_next = ctl_m3_reg.is_exit ? ONE_Q - {1'b0, t3_reg} : {1'b0, t3_reg};
        end
        else
        begin
            case (ctl_m3_reg.kind)
                KIND_SLIDE:
                begin
                    slide_next = slide_mul_reg;
                    if (!ctl_m3_reg.is_exit)
                    begin
                        scale_next = {1'b0, KQ_96} + {1'b0, scale_mul_reg};
                    end
                end
                KIND_SCALE:
                begin
                    if (!ctl_m3_reg.is_exit)
                    begin
                        scale_next = {1'b0, KQ_90} + {1'b0, scale_mul_reg};
                    end
                    else if (scale_mul_reg > ONE_Q)
                    begin
                        scale_next = '0;
                    end
                    else
                    begin
                        scale_next = {1'b0, ONE_Q - scale_mul_reg};
                    end
                end
                default:
                begin
                    scale_next = {1'b0, ONE_Q};
                end
            endcase
            // constant rounding can push scale a hair over unity
            if (scale_next > {1'b0, ONE_Q})
            begin
                scale_next = {1'b0, ONE_Q};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl_m3_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        opacity_reg  <= opacity_next[16:0];
        scale_reg    <= scale_next[16:0];
        slide_reg    <= slide_next[15:0];
        finished_reg <= finished_next;
    end

    assign done             = done_reg;
    assign opacity_q16      = opacity_reg;
    assign scale_q16        = scale_reg;
    assign slide_offset_q16 = slide_reg;
    assign finished         = finished_reg;

endmodule

>>> rtl/core/efssc_checker.sv
// ----------------------------------------------------------------------------
// efssc_checker
// Port-level checks on item timing and end values of the curve block.
// ----------------------------------------------------------------------------
module efssc_checker
    import efssc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [31:0] duration_ticks,
    input logic [1:0]  animation_kind,
    input logic        reduced_motion,
    input logic        done,
    input logic [16:0] opacity_q16,
    input logic [16:0] scale_q16,
    input logic [15:0] slide_offset_q16,
    input logic        finished
);

    // every taken item yields a result a fixed time later
    a_item_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LATENCY done)
        else $error("taken item produced no result");

    // no result without a matching taken item
    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_LATENCY))
        else $error("result without a matching item");

    // finished results carry end values
    a_end_values: assert property (@(posedge clk) disable iff (!rst_n)
        (done && finished) |->
            (scale_q16 == 17'(ONE_Q)) && (slide_offset_q16 == '0) &&
            ((opacity_q16 == '0) || (opacity_q16 == 17'(ONE_Q))))
        else $error("finished result without end values");

    // kind none, or zero duration without reduced motion, ends at once
    a_immediate_end: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy &&
         ((animation_kind == KIND_NONE) || (!reduced_motion && (duration_ticks == '0))))
        |-> ##PIPE_LATENCY (done && finished))
        else $error("item expected to end at once was not finished");

endmodule

bind eased_fade_scale_slide_curve_top efssc_checker u_efssc_checker (.*);
